/* design/assert_macros.svh */
// Assertion macros for the checker file of the fixed-point ALU.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property sampled on the rising clock edge, disabled during reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same check with the clock and reset names used throughout this project.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* design/fpa_pkg.sv */
// Package of the fixed-point ALU: widths, opcodes, payload and stage types.
// Has no dependencies; the ALU design files and the checker refer to it by scoped names.
package fpa_pkg;

  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIV_BPS    = 2;
  localparam int unsigned DIVD_W     = DATA_W + FRAC_BITS;
  localparam int unsigned DIV_STAGES = (DIVD_W + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned DIVP_W     = DIV_STAGES * DIV_BPS;
  localparam int unsigned REM_W      = DATA_W + 1;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } opcode_e;

  typedef struct packed {
    logic [3:0]               opcode;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     compare_true;
    logic                     divide_by_zero;
  } out_t;

  // Results known after the first stage, carried alongside the divider.
  typedef struct packed {
    logic              is_div;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic              cmp;
    logic              dz;
  } side_t;

  // Restoring divider state: remaining dividend bits shift out at the top of
  // quo while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIVP_W-1:0] quo;
    logic [DATA_W-1:0] divisor;
  } div_t;

  typedef struct packed {
    side_t side;
    div_t  dv;
  } stage_t;

endpackage

/* design/fpa_front.sv */
// First pipeline stage: decode, the combinational operations, the multiplier and
// divider setup. Depends on fpa_pkg.
module fpa_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fpa_pkg::in_t    data_i,
  output logic            valid_o,
  output fpa_pkg::stage_t stage_o
);

  logic signed [fpa_pkg::DATA_W-1:0]   a, b;
  logic [fpa_pkg::DATA_W-1:0]          mag_a, mag_b;
  logic signed [2*fpa_pkg::DATA_W-1:0] prod;
  fpa_pkg::stage_t                     stage_d, stage_q;
  logic                                valid_q;

  always_comb begin
    a       = data_i.operand_a;
    b       = data_i.operand_b;
    mag_a   = a[fpa_pkg::DATA_W-1] ? (~a + 1'b1) : a;
    mag_b   = b[fpa_pkg::DATA_W-1] ? (~b + 1'b1) : b;
    prod    = a * b;
    stage_d = '0;
    stage_d.side.neg    = a[fpa_pkg::DATA_W-1] ^ b[fpa_pkg::DATA_W-1];
    stage_d.dv.rem      = '0;
    stage_d.dv.quo      = fpa_pkg::DIVP_W'({mag_a, {fpa_pkg::FRAC_BITS{1'b0}}});
    stage_d.dv.divisor  = mag_b;
    unique case (fpa_pkg::opcode_e'(data_i.opcode))
      fpa_pkg::OP_ADD:     stage_d.side.res = a + b;
      fpa_pkg::OP_SUB:     stage_d.side.res = a - b;
      fpa_pkg::OP_MUL:
        stage_d.side.res = prod[fpa_pkg::FRAC_BITS+fpa_pkg::DATA_W-1:fpa_pkg::FRAC_BITS];
      fpa_pkg::OP_DIV: begin
        stage_d.side.is_div = (b != '0);
        stage_d.side.dz     = (b == '0);
      end
      fpa_pkg::OP_GT:      stage_d.side.cmp = (a > b);
      fpa_pkg::OP_LT:      stage_d.side.cmp = (a < b);
      fpa_pkg::OP_GE:      stage_d.side.cmp = (a >= b);
      fpa_pkg::OP_LE:      stage_d.side.cmp = (a <= b);
      fpa_pkg::OP_EQ:      stage_d.side.cmp = (a == b);
      fpa_pkg::OP_NE:      stage_d.side.cmp = (a != b);
      fpa_pkg::OP_MIN:     stage_d.side.res = (a < b) ? a : b;
      fpa_pkg::OP_MAX:     stage_d.side.res = (a > b) ? a : b;
      fpa_pkg::OP_INC:     stage_d.side.res = a + 1'b1;
      fpa_pkg::OP_DEC:     stage_d.side.res = a - 1'b1;
      fpa_pkg::OP_TOINT:   stage_d.side.res = a >>> fpa_pkg::FRAC_BITS;
      fpa_pkg::OP_FROMINT: stage_d.side.res = a << fpa_pkg::FRAC_BITS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

/* design/fpa_div_stage.sv */
// One divider stage: DIV_BPS restoring division steps and a pipeline register.
// Depends on fpa_pkg.
module fpa_div_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fpa_pkg::stage_t stage_i,
  output logic            valid_o,
  output fpa_pkg::stage_t stage_o
);

  function automatic fpa_pkg::div_t div_step(fpa_pkg::div_t s);
    fpa_pkg::div_t          r;
    logic [fpa_pkg::REM_W-1:0] trial;
    logic                      qbit;
    trial = {s.rem[fpa_pkg::REM_W-2:0], s.quo[fpa_pkg::DIVP_W-1]};
    qbit  = (trial >= {1'b0, s.divisor});
    r.divisor = s.divisor;
    r.rem     = qbit ? (trial - {1'b0, s.divisor}) : trial;
    r.quo     = {s.quo[fpa_pkg::DIVP_W-2:0], qbit};
    return r;
  endfunction

  fpa_pkg::stage_t stage_d, stage_q;
  logic            valid_q;

  always_comb begin
    stage_d = stage_i;
    for (int i = 0; i < fpa_pkg::DIV_BPS; i++) begin
      stage_d.dv = div_step(stage_d.dv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

/* design/fpa_back.sv */
// Last pipeline stage: applies the quotient sign and picks the final result.
// Depends on fpa_pkg.
module fpa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fpa_pkg::stage_t stage_i,
  output logic            valid_o,
  output fpa_pkg::out_t   data_o
);

  logic [fpa_pkg::DATA_W-1:0] q;
  fpa_pkg::out_t              data_d, data_q;
  logic                       valid_q;

  always_comb begin
    q = stage_i.dv.quo[fpa_pkg::DATA_W-1:0];
    data_d.compare_true   = stage_i.side.cmp;
    data_d.divide_by_zero = stage_i.side.dz;
    if (stage_i.side.is_div) begin
      data_d.result_value = stage_i.side.neg ? (~q + 1'b1) : q;
    end else begin
      data_d.result_value = stage_i.side.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/fpa_out_buf.sv */
// Two-entry output buffer that decouples the pipeline advance from the
// downstream ready. Depends on fpa_pkg.
module fpa_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fpa_pkg::out_t push_data_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::out_t out_data_o
);

  fpa_pkg::out_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign room_o      = (count_q != 2'd2);
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/fixed_point_alu_q24_8.sv */
// Signed Q24.8 fixed-point ALU, fully pipelined.
// From input acceptance to output valid, every result passes the front stage, the
// radix-4 divider stages, the back stage and the output buffer.
// Throughput: one transaction per cycle while the output side keeps taking results.
// Reset: asynchronous, active low; it clears all valid bits and the output buffer,
// payload registers are not reset.
module fixed_point_alu_q24_8 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpa_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::out_t out_data_o
);

  // The whole pipeline advances together. It moves whenever the output buffer
  // has a free entry, so ready comes from a register and not from out_ready_i.
  // Bubbles travel as cleared valid bits and are simply dropped at the end.
  logic            en;
  logic            room;
  logic            back_valid;
  fpa_pkg::out_t   back_data;

  // Stage 0 of these arrays is the output of the front stage; entry k+1 is the
  // output of divider stage k.
  logic            pipe_valid [fpa_pkg::DIV_STAGES+1];
  fpa_pkg::stage_t pipe_stage [fpa_pkg::DIV_STAGES+1];

  assign en         = room;
  assign in_ready_o = en;

  // Front stage: decode, add/sub/compare/shift, the 32x32 multiplier, and the
  // magnitudes and shifted dividend for the divider.
  fpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (pipe_valid[0]),
    .stage_o (pipe_stage[0])
  );

  // Restoring division on magnitudes, two quotient bits per stage. Every
  // transaction passes through these stages so that latency is the same for
  // all opcodes and results stay in order.
  for (genvar k = 0; k < fpa_pkg::DIV_STAGES; k++) begin : g_div
    fpa_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (pipe_valid[k]),
      .stage_i (pipe_stage[k]),
      .valid_o (pipe_valid[k+1]),
      .stage_o (pipe_stage[k+1])
    );
  end

  // Final stage: sign of the quotient and result selection.
  fpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pipe_valid[fpa_pkg::DIV_STAGES]),
    .stage_i (pipe_stage[fpa_pkg::DIV_STAGES]),
    .valid_o (back_valid),
    .data_o  (back_data)
  );

  // A result leaves the last stage exactly when the pipeline advances.
  fpa_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (en && back_valid),
    .push_data_i (back_data),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/fpa_checker.sv */
// Port-level checker for the fixed-point ALU and its bind to the top level.
// Depends on fpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input fpa_pkg::out_t out_data_o
);

  `ASSERT_STD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output valid dropped")
  `ASSERT_STD(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "payload moved")
  `ASSERT_STD(a_stall_full, !in_ready_o |-> out_valid_o, "input stalled with no result")
  `ASSERT_STD(a_dz_zero, out_valid_o && out_data_o.divide_by_zero |-> out_data_o.result_value == '0 && !out_data_o.compare_true, "bad divide by zero result")
  `ASSERT_STD(a_cmp_zero, out_valid_o && out_data_o.compare_true |-> out_data_o.result_value == '0, "comparison with nonzero value")

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
